// File: rtl/beqf_pkg.sv
// Shared types and constants for the bounded event queue.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package beqf_pkg;

  localparam int unsigned TAG_W     = 32;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  // option bit positions
  localparam int unsigned OPT_SKIP  = 0;
  localparam int unsigned OPT_FRONT = 1;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_GET   = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH,
    S_INS,
    S_GETD
  } state_e;

  typedef struct packed {
    logic [TAG_W-1:0]     tag;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

endpackage

// File: rtl/beqf_req_if.sv
// Request channel of the event queue: kind, tag, payload word, options.
// Depends on beqf_pkg for field widths.
`timescale 1ns / 1ps

interface beqf_req_if import beqf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [TAG_W-1:0]     event_tag;
  logic [PAYLOAD_W-1:0] payload_in;
  logic [1:0]           add_options;

  modport source (output valid, kind, event_tag, payload_in, add_options, input ready);
  modport sink   (input valid, kind, event_tag, payload_in, add_options, output ready);
endinterface

// File: rtl/beqf_rsp_if.sv
// Response channel of the event queue: status, popped entry, query hit, free space.
// Depends on beqf_pkg for field widths.
`timescale 1ns / 1ps

interface beqf_rsp_if import beqf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [TAG_W-1:0]     tag_out;
  logic [PAYLOAD_W-1:0] payload_out;
  logic                 tag_found;
  logic [CAP_W-1:0]     free_space;

  modport source (output valid, status, tag_out, payload_out, tag_found, free_space,
                  input ready);
  modport sink   (input valid, status, tag_out, payload_out, tag_found, free_space,
                  output ready);
endinterface

// File: rtl/beqf_mem.sv
// Entry store: one write port, one read port with registered read data.
// Depends on beqf_pkg for the entry type.
`timescale 1ns / 1ps

module beqf_mem import beqf_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/beqf_ctrl.sv
// Sequencer of the event queue: ring pointers, entry count, tag walk with one
// shared comparator, and the response register. Depends on beqf_pkg and both channels.
`timescale 1ns / 1ps

module beqf_ctrl import beqf_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CAP_W-1:0]  capacity_i,
  beqf_req_if.sink          req,
  beqf_rsp_if.source        rsp,
  output logic              we_o,
  output logic [AW-1:0]     waddr_o,
  output entry_t            wdata_o,
  output logic              re_o,
  output logic [AW-1:0]     raddr_o,
  input  entry_t            rdata_i
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned SW = CW + 1;
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [EW-1:0] DEPTH_E  = EW'(DEPTH);

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(logic [AW-1:0] p);
    return (p == '0) ? PTR_LAST : p - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_add(logic [AW-1:0] p, logic [CW-1:0] n);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(n);
    if (s >= DEPTH_S) s = s - DEPTH_S;
    return s[AW-1:0];
  endfunction

  state_e               state_q, state_d;
  logic [1:0]           kind_q, kind_d;
  logic [TAG_W-1:0]     tag_q, tag_d;
  logic [PAYLOAD_W-1:0] pay_q, pay_d;
  logic [1:0]           opt_q, opt_d;
  logic [AW-1:0]        head_q, head_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        srch_cnt_q, srch_cnt_d;
  logic [AW-1:0]        srch_ptr_q, srch_ptr_d;
  logic                 cmp_v_q, cmp_v_d;
  logic                 rsp_valid_q, rsp_valid_d;
  status_e              rsp_status_q;
  logic [TAG_W-1:0]     rsp_tag_q;
  logic [PAYLOAD_W-1:0] rsp_pay_q;
  logic                 rsp_found_q;
  logic [CAP_W-1:0]     rsp_free_q;

  logic                 fin;
  status_e              fin_status;
  logic [TAG_W-1:0]     fin_tag;
  logic [PAYLOAD_W-1:0] fin_pay;
  logic                 fin_found;
  logic [CAP_W-1:0]     fin_free;

  logic [EW-1:0]        cap_e, eff_cap, cnt_next_e, free_e;
  logic                 full, hit;

  // effective capacity is min(capacity, DEPTH)
  assign cap_e   = EW'(capacity_i);
  assign eff_cap = (cap_e < DEPTH_E) ? cap_e : DEPTH_E;
  assign full    = EW'(count_q) >= eff_cap;

  // shared comparator on the word read in the cycle before
  assign hit = cmp_v_q && (rdata_i.tag == tag_q);

  assign cnt_next_e = EW'(count_d);
  assign free_e     = (eff_cap > cnt_next_e) ? eff_cap - cnt_next_e : '0;
  assign fin_free   = free_e[CAP_W-1:0];

  assign wdata_o = '{tag: tag_q, payload: pay_q};

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    tag_d       = tag_q;
    pay_d       = pay_q;
    opt_d       = opt_q;
    head_d      = head_q;
    count_d     = count_q;
    srch_cnt_d  = srch_cnt_q;
    srch_ptr_d  = srch_ptr_q;
    cmp_v_d     = cmp_v_q;
    rsp_valid_d = rsp_valid_q;
    we_o        = 1'b0;
    waddr_o     = head_q;
    re_o        = 1'b0;
    raddr_o     = head_q;
    fin         = 1'b0;
    fin_status  = ST_OK;
    fin_tag     = '0;
    fin_pay     = '0;
    fin_found   = 1'b0;
    req.ready   = (state_q == S_IDLE) && !rsp_valid_q;

    if (rsp_valid_q && rsp.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          kind_d  = req.kind;
          tag_d   = req.event_tag;
          pay_d   = req.payload_in;
          opt_d   = req.add_options;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        srch_cnt_d = '0;
        srch_ptr_d = head_q;
        cmp_v_d    = 1'b0;
        case (kind_q)
          KIND_ADD: begin
            if (full) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else if (opt_q[OPT_SKIP]) begin
              state_d = S_SRCH;
            end else begin
              state_d = S_INS;
            end
          end
          KIND_GET: begin
            if (count_q == '0) begin
              fin        = 1'b1;
              fin_status = ST_EMPTY;
            end else begin
              re_o    = 1'b1;
              raddr_o = head_q;
              state_d = S_GETD;
            end
          end
          KIND_QUERY: state_d = S_SRCH;
          default:    fin = 1'b1;
        endcase
      end
      S_SRCH: begin
        if (hit) begin
          // skipped duplicate add or query hit
          fin       = 1'b1;
          fin_found = (kind_q == KIND_QUERY);
        end else if (!cmp_v_q && (srch_cnt_q == count_q)) begin
          if (kind_q == KIND_ADD) begin
            state_d = S_INS;
          end else begin
            fin = 1'b1;
          end
        end else begin
          cmp_v_d = 1'b0;
          if (srch_cnt_q < count_q) begin
            re_o       = 1'b1;
            raddr_o    = srch_ptr_q;
            srch_cnt_d = srch_cnt_q + CW'(1);
            srch_ptr_d = ptr_inc(srch_ptr_q);
            cmp_v_d    = 1'b1;
          end
        end
      end
      S_INS: begin
        we_o = 1'b1;
        if (opt_q[OPT_FRONT]) begin
          waddr_o = ptr_dec(head_q);
          head_d  = ptr_dec(head_q);
        end else begin
          waddr_o = ptr_add(head_q, count_q);
        end
        count_d = count_q + CW'(1);
        fin     = 1'b1;
      end
      S_GETD: begin
        fin     = 1'b1;
        fin_tag = rdata_i.tag;
        fin_pay = rdata_i.payload;
        head_d  = ptr_inc(head_q);
        count_d = count_q - CW'(1);
      end
      default: state_d = S_IDLE;
    endcase

    if (fin) begin
      state_d     = S_IDLE;
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      srch_cnt_q  <= '0;
      srch_ptr_q  <= '0;
      cmp_v_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      srch_cnt_q  <= srch_cnt_d;
      srch_ptr_q  <= srch_ptr_d;
      cmp_v_q     <= cmp_v_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    tag_q  <= tag_d;
    pay_q  <= pay_d;
    opt_q  <= opt_d;
    if (fin) begin
      rsp_status_q <= fin_status;
      rsp_tag_q    <= fin_tag;
      rsp_pay_q    <= fin_pay;
      rsp_found_q  <= fin_found;
      rsp_free_q   <= fin_free;
    end
  end

  assign rsp.valid       = rsp_valid_q;
  assign rsp.status      = rsp_status_q;
  assign rsp.tag_out     = rsp_tag_q;
  assign rsp.payload_out = rsp_pay_q;
  assign rsp.tag_found   = rsp_found_q;
  assign rsp.free_space  = rsp_free_q;

endmodule

// File: rtl/bounded_event_queue_front_insert_dedup.sv
// Bounded event queue with front insertion and duplicate skipping.
// Get and plain add end in the insert or read-data state after the execute state; refused
// add, empty get and no-op finish in the execute state; skip-add and query walk the queue
// one entry per cycle through the store's single read port. One word at a time: the next
// word is taken once the result has been taken. Reset clears pointers, count and handshakes
// and sets capacity to 16; the entry store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module bounded_event_queue_front_insert_dedup import beqf_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  beqf_req_if.sink          req_i,
  beqf_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CAP_W-1:0] capacity_q;
  logic             cfg_wr;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  // APB register file: capacity at byte address 0, write on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  // read back capacity, zero for unmapped addresses
  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(capacity_q) : '0;

  // sequencer: ring pointers, count, tag walk, response register
  beqf_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .capacity_i (capacity_q),
    .req        (req_i),
    .rsp        (rsp_o),
    .we_o       (mem_we),
    .waddr_o    (mem_waddr),
    .wdata_o    (mem_wdata),
    .re_o       (mem_re),
    .raddr_o    (mem_raddr),
    .rdata_i    (mem_rdata)
  );

  // entry ring: front at the head pointer
  beqf_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// File: rtl/beqf_checker.sv
// Port-level checks of the event queue, attached to the top level by bind.
// Depends on beqf_pkg for status codes.
`timescale 1ns / 1ps

module beqf_checker import beqf_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [1:0]           out_status_i,
  input logic [TAG_W-1:0]     out_tag_i,
  input logic [PAYLOAD_W-1:0] out_pay_i,
  input logic                 out_found_i
);

  // hold a stalled result word
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_tag_i) && $stable(out_pay_i) && $stable(out_found_i))
    else $error("result word changed while stalled");

  // one word in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after an accept");

  // error results carry no entry and no hit
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != ST_OK) |->
      (out_tag_i == '0) && (out_pay_i == '0) && !out_found_i)
    else $error("error result carries data");

  // a query hit never comes with a popped entry
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_found_i |->
      (out_status_i == ST_OK) && (out_tag_i == '0) && (out_pay_i == '0))
    else $error("query hit carries popped data");

endmodule

bind bounded_event_queue_front_insert_dedup beqf_checker u_beqf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_status_i (rsp_o.status),
  .out_tag_i    (rsp_o.tag_out),
  .out_pay_i    (rsp_o.payload_out),
  .out_found_i  (rsp_o.tag_found)
);

// File: tb/tb_bounded_event_queue_front_insert_dedup.sv
// Self-checking bench for bounded_event_queue_front_insert_dedup: directed table, then random phases
// under several capacity settings, results checked against typed-in values or an in-bench predictor.
// Depends on beqf_pkg and the beqf_req_if / beqf_rsp_if interfaces of the RTL.
`timescale 1ns / 1ps

module tb_bounded_event_queue_front_insert_dedup import beqf_pkg::*; ();

  localparam int unsigned QDEPTH      = 16;
  localparam int unsigned IDLE_PCT    = 31;    // idle share of cycles on each side
  localparam int unsigned SETTLE_CYC  = 8;     // quiet cycles before a register write
  localparam int unsigned TAIL_CYC    = 40;    // idle cycles after the drain before judging
  localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no word moved and no register access before giving up
  localparam int unsigned HOLD_CYC    = 150;   // receiver hold-off in the first random phase
  localparam int unsigned RAND_WORDS  = 850;

  // kind three is outside the package enum: the block treats it as a no-op
  localparam logic [1:0] KIND_NOP = 2'd3;

  // byte addresses of the register file; the second slot is unmapped
  localparam logic [APB_AW-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_SPARE    = {~REG_CAPACITY, 2'b00};

  localparam logic [1:0] OPT_NONE = 2'b00;
  localparam logic [1:0] OPT_S    = 2'b01;
  localparam logic [1:0] OPT_F    = 2'b10;
  localparam logic [1:0] OPT_SF   = 2'b11;

  typedef struct packed {
    logic [1:0]           kind;
    logic [TAG_W-1:0]     tag;
    logic [PAYLOAD_W-1:0] payload;
    logic [1:0]           opts;
  } qreq_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [TAG_W-1:0]     tag;
    logic [PAYLOAD_W-1:0] payload;
    logic                 found;
    logic [CAP_W-1:0]     free;
  } qrsp_t;

  // one line of the directed table: either a register write or a word to send
  typedef struct {
    bit                  is_cfg;
    logic [APB_AW-1:0]   addr;
    logic [APB_DW-1:0]   value;
    qreq_t               w;
    bit                  typed;
    qrsp_t               want;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  beqf_req_if req_if ();
  beqf_rsp_if rsp_if ();

  bounded_event_queue_front_insert_dedup #(.DEPTH(QDEPTH)) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: a shadow of the queued entries, front at index 0,
  // and the capacity register as last written.
  logic [TAG_W-1:0]     held_tags[$];
  logic [PAYLOAD_W-1:0] held_words[$];
  logic [CAP_W-1:0]     cap_reg = CAP_RESET;

  qrsp_t pending_results[$];
  qrsp_t head;
  row_t  rows[$];

  logic [TAG_W-1:0] tag_pool[8];

  int errors = 0;
  int n_sent = 0;
  int n_seen = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_hit = 0;
  int n_skip = 0;
  int n_front = 0;
  int n_cfg = 0;
  int hold_len = 0;
  int quiet = 0;
  bit calm = 1'b0;

  task automatic report(string field, logic [31:0] want, logic [31:0] got);
    $display("mismatch at result word %0d, %s: expected %h, got %h", n_seen, field, want, got);
    errors++;
  endtask

  function automatic int eff_capacity();
    return (cap_reg < QDEPTH) ? int'(cap_reg) : int'(QDEPTH);
  endfunction

  function automatic bit tag_held(logic [TAG_W-1:0] t);
    foreach (held_tags[i])
      if (held_tags[i] == t) return 1'b1;
    return 1'b0;
  endfunction

  // Apply one word to the shadow queue and return the result word it yields.
  function automatic qrsp_t apply_queue_op(qreq_t w);
    qrsp_t o;
    int    cap;
    o = '0;
    o.status = ST_OK;
    cap = eff_capacity();
    case (w.kind)
      KIND_ADD: begin
        // the full test comes before the duplicate test
        if (held_tags.size() >= cap) begin
          o.status = ST_FULL;
          n_full++;
        end else if (w.opts[OPT_SKIP] && tag_held(w.tag)) begin
          n_skip++;
        end else if (w.opts[OPT_FRONT]) begin
          held_tags.push_front(w.tag);
          held_words.push_front(w.payload);
          n_front++;
        end else begin
          held_tags.push_back(w.tag);
          held_words.push_back(w.payload);
        end
      end
      KIND_GET: begin
        if (held_tags.size() == 0) begin
          o.status = ST_EMPTY;
          n_empty++;
        end else begin
          o.tag = held_tags.pop_front();
          o.payload = held_words.pop_front();
        end
      end
      KIND_QUERY: begin
        o.found = tag_held(w.tag);
        if (o.found) n_hit++;
      end
      default: ;
    endcase
    cap = eff_capacity();
    o.free = (cap > held_tags.size()) ? CAP_W'(cap - held_tags.size()) : '0;
    return o;
  endfunction

  // Table builders: a predicted word, a word with its result typed in, a register write.
  function automatic void row_op(logic [1:0] k, logic [31:0] t, logic [31:0] p, logic [1:0] o);
    row_t r;
    r = '{default: '0};
    r.w = '{kind: k, tag: t, payload: p, opts: o};
    rows.push_back(r);
  endfunction

  function automatic void row_typed(logic [1:0] k, logic [31:0] t, logic [31:0] p,
                                    logic [1:0] o, logic [1:0] st, logic [31:0] tag_o,
                                    logic [31:0] pay_o, logic fnd, logic [CAP_W-1:0] fr);
    row_t r;
    r = '{default: '0};
    r.w = '{kind: k, tag: t, payload: p, opts: o};
    r.typed = 1'b1;
    r.want = '{status: st, tag: tag_o, payload: pay_o, found: fnd, free: fr};
    rows.push_back(r);
  endfunction

  function automatic void row_cfg(logic [APB_AW-1:0] a, logic [APB_DW-1:0] v);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.addr = a;
    r.value = v;
    rows.push_back(r);
  endfunction

  // Offer one word, hold it until taken, then predict. Enter and leave at a falling edge.
  task automatic issue_word(qreq_t w, bit typed, qrsp_t want);
    qrsp_t got;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.kind        <= w.kind;
    req_if.event_tag   <= w.tag;
    req_if.payload_in  <= w.payload;
    req_if.add_options <= w.opts;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    got = apply_queue_op(w);
    pending_results.push_back(typed ? want : got);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected word is back, then let the block go quiet.
  task automatic settle();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  // Write a register with setup and access cycles; read the capacity back after a write to it.
  task automatic write_register(logic [APB_AW-1:0] a, logic [APB_DW-1:0] v);
    logic [APB_DW-1:0] rd;
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (a == ADDR_CAPACITY) cap_reg = v[CAP_W-1:0];
    n_cfg++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (a == ADDR_CAPACITY) begin
      @(negedge clk_i);
      psel   <= 1'b1;
      pwrite <= 1'b0;
      @(negedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      rd = prdata;
      if (rd[CAP_W-1:0] !== cap_reg)
        report("capacity readback", 32'(cap_reg), 32'(rd[CAP_W-1:0]));
      @(negedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // Random word: adds at the phase's rate, otherwise mostly gets and queries, with rare no-ops.
  // Half the tags come from a small pool so duplicates and query hits are common.
  function automatic qreq_t random_word(int add_pct);
    qreq_t w;
    int    roll;
    roll = $urandom_range(99);
    if (roll < add_pct)            w.kind = KIND_ADD;
    else if ($urandom_range(99) < 55) w.kind = KIND_GET;
    else if ($urandom_range(99) < 90) w.kind = KIND_QUERY;
    else                           w.kind = KIND_NOP;
    w.tag     = $urandom_range(1) ? tag_pool[$urandom_range(7)] : $urandom();
    w.payload = $urandom();
    w.opts    = 2'($urandom_range(3));
    return w;
  endfunction

  // Check each taken result word against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      n_seen++;
      if (pending_results.size() == 0) begin
        report("word with nothing expected", '0, {30'b0, rsp_if.status});
      end else begin
        head = pending_results.pop_front();
        if (rsp_if.status !== head.status)
          report("status", 32'(head.status), 32'(rsp_if.status));
        if (rsp_if.tag_out !== head.tag)       report("tag_out", head.tag, rsp_if.tag_out);
        if (rsp_if.payload_out !== head.payload)
          report("payload_out", head.payload, rsp_if.payload_out);
        if (rsp_if.tag_found !== head.found)
          report("tag_found", 32'(head.found), 32'(rsp_if.tag_found));
        if (rsp_if.free_space !== head.free)
          report("free_space", 32'(head.free), 32'(rsp_if.free_space));
      end
    end
  end

  // Watchdog: any word moved on either channel or a register access resets the count.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || (psel && penable))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d words still expected",
               quiet, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result-side ready: random idling, or a counted hold-off when one is requested.
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
      end else begin
        rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int    phase_caps[7];
    int    total;
    int    phase;
    int    cap;
    int    len;
    int    add_pct;
    bit    paused;
    qrsp_t none;

    req_if.valid       = 1'b0;
    req_if.kind        = KIND_ADD;
    req_if.event_tag   = '0;
    req_if.payload_in  = '0;
    req_if.add_options = OPT_NONE;
    none = '0;

    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 8; i++) tag_pool[i] = $urandom();
    phase_caps = '{16, 3, 31, 1, 0, 8, 2};

    // Directed table. Capacity is 16 out of reset.
    row_typed(KIND_GET,   32'h0, 32'h0, OPT_NONE, ST_EMPTY, 32'h0, 32'h0, 1'b0, 5'd16);
    row_typed(KIND_QUERY, 32'h0, 32'h0, OPT_NONE, ST_OK, 32'h0, 32'h0, 1'b0, 5'd16);
    row_typed(KIND_NOP, '1, '1, OPT_SF, ST_OK, 32'h0, 32'h0, 1'b0, 5'd16);
    row_typed(KIND_ADD, '1, 32'h0, OPT_NONE, ST_OK, 32'h0, 32'h0, 1'b0, 5'd15);
    row_typed(KIND_ADD, 32'h0, '1, OPT_F, ST_OK, 32'h0, 32'h0, 1'b0, 5'd14);
    // duplicates with the skip option are taken but not stored
    row_typed(KIND_ADD, '1, 32'h5a5a5a5a, OPT_S, ST_OK, 32'h0, 32'h0, 1'b0, 5'd14);
    row_typed(KIND_ADD, 32'h0, 32'h1, OPT_SF, ST_OK, 32'h0, 32'h0, 1'b0, 5'd14);
    row_op(KIND_ADD, 32'ha5a5a5a5, 32'h12345678, OPT_F);
    // options must be ignored on a query or a get
    row_typed(KIND_QUERY, '1, 32'h0, OPT_SF, ST_OK, 32'h0, 32'h0, 1'b1, 5'd13);
    row_typed(KIND_GET, 32'h0, 32'h0, OPT_SF, ST_OK, 32'ha5a5a5a5, 32'h12345678, 1'b0, 5'd14);
    row_typed(KIND_GET, 32'h0, 32'h0, OPT_NONE, ST_OK, 32'h0, '1, 1'b0, 5'd15);
    row_typed(KIND_GET, 32'h0, 32'h0, OPT_NONE, ST_OK, '1, 32'h0, 1'b0, 5'd16);
    // capacity one: a duplicate add when full reports full
    row_cfg(ADDR_CAPACITY, 32'd1);
    row_typed(KIND_ADD, 32'h7, 32'h8, OPT_NONE, ST_OK, 32'h0, 32'h0, 1'b0, 5'd0);
    row_typed(KIND_ADD, 32'h7, 32'h9, OPT_S, ST_FULL, 32'h0, 32'h0, 1'b0, 5'd0);
    row_typed(KIND_GET, 32'h0, 32'h0, OPT_NONE, ST_OK, 32'h7, 32'h8, 1'b0, 5'd1);
    // capacity zero refuses every add
    row_cfg(ADDR_CAPACITY, 32'd0);
    row_typed(KIND_ADD, 32'h1, 32'h2, OPT_NONE, ST_FULL, 32'h0, 32'h0, 1'b0, 5'd0);
    row_typed(KIND_GET, 32'h0, 32'h0, OPT_NONE, ST_EMPTY, 32'h0, 32'h0, 1'b0, 5'd0);
    // capacity above the store depth is clamped; the unmapped slot must not touch it
    row_cfg(ADDR_CAPACITY, 32'd31);
    row_cfg(ADDR_SPARE, 32'd1);
    for (int i = 0; i < 4; i++) row_op(KIND_ADD, 32'h10 + i, 32'hc0de0000 + i, OPT_NONE);
    // capacity lowered under the count: entries stay, adds refused until drained below it
    row_cfg(ADDR_CAPACITY, 32'd2);
    row_typed(KIND_ADD, 32'h20, 32'h21, OPT_NONE, ST_FULL, 32'h0, 32'h0, 1'b0, 5'd0);
    row_op(KIND_GET, 32'h0, 32'h0, OPT_NONE);
    row_op(KIND_GET, 32'h0, 32'h0, OPT_NONE);
    row_op(KIND_GET, 32'h0, 32'h0, OPT_NONE);
    row_op(KIND_ADD, 32'h22, 32'h23, OPT_F);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table.
    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_register(rows[i].addr, rows[i].value);
      else issue_word(rows[i].w, rows[i].typed, rows[i].want);
    end

    // Random phases, each under its own capacity. The first phase opens with a long
    // receiver hold-off while words keep coming; the third runs with no idling at all.
    total  = 0;
    phase  = 0;
    paused = 1'b0;
    while (total < RAND_WORDS) begin
      cap = (phase < 7) ? phase_caps[phase] : $urandom_range(0, 31);
      len = (cap == 0) ? 20 : $urandom_range(60, 130);
      add_pct = $urandom_range(35, 75);
      write_register(ADDR_CAPACITY, cap);
      calm = (phase == 2);
      if (phase == 0) hold_len = HOLD_CYC;
      for (int k = 0; k < len && total < RAND_WORDS; k++) begin
        // once, stop mid-phase until the block has answered everything
        if (!paused && total >= RAND_WORDS / 2) begin
          settle();
          paused = 1'b1;
        end
        issue_word(random_word(add_pct), 1'b0, none);
        total++;
      end
      phase++;
    end
    calm = 1'b0;

    // Drain, then give the block time to misbehave before judging.
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYC) @(negedge clk_i);

    $display("run: %0d words sent, %0d results checked, %0d register writes, %0d phases",
             n_sent, n_seen, n_cfg, phase);
    $display("run: %0d full, %0d empty, %0d query hits, %0d skipped dups, %0d front inserts",
             n_full, n_empty, n_hit, n_skip, n_front);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
